/* rtl/core/vsp_pkg.sv */
// Shared types, widths and codes for the VAD segment postprocessor.
// No dependencies; every other file of the block depends on this package.
package vsp_pkg;

	localparam int PROB_W         = 16;
	localparam int IDX_W          = 32;
	localparam int FRAME_W        = 33;
	localparam int RUN_W          = 16;
	localparam int PAD_W          = 10;
	localparam int SMOOTH_W       = 5;
	localparam int THR_W          = 16;
	localparam int MAX_WINDOW_DEF = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = 2;
	localparam int PADDR_W        = 5;
	localparam int PDATA_W        = 32;

	// Segment start or end that is not reported this frame
	localparam logic [FRAME_W-1:0] FRAME_NONE = '1;

	typedef enum logic [2:0] {
		REG_SMOOTH_LEN    = 3'd0,
		REG_SPEECH_THR    = 3'd1,
		REG_PAD_FRAMES    = 3'd2,
		REG_MIN_SPEECH    = 3'd3,
		REG_MAX_SPEECH    = 3'd4,
		REG_MIN_SILENCE   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_SILENCE       = 2'd0,
		MODE_MAYBE_SPEECH  = 2'd1,
		MODE_SPEECH        = 2'd2,
		MODE_MAYBE_SILENCE = 2'd3
	} vad_mode_t;

	typedef struct packed {
		logic [THR_W-1:0] speech_threshold;
		logic [PAD_W-1:0] pad_frames;
		logic [RUN_W-1:0] min_speech_frames;
		logic [RUN_W-1:0] max_speech_frames;
		logic [RUN_W-1:0] min_silence_frames;
	} cfg_t;

	// One classified frame travelling from the front end to the segmenter
	typedef struct packed {
		logic valid;
		logic speech;
	} frame_cls_t;

endpackage

/* rtl/core/vsp_if.sv */
// Stream interfaces for probability input beats and segment result beats.
// Depends on vsp_pkg for field widths.
interface vsp_in_if;
	logic                        valid;
	logic                        ready;
	logic [vsp_pkg::PROB_W-1:0]  frame_prob;

	modport source (output valid, output frame_prob, input ready);
	modport sink   (input valid, input frame_prob, output ready);
endinterface

interface vsp_out_if;
	logic                        valid;
	logic                        ready;
	logic [vsp_pkg::IDX_W-1:0]   frame_index;
	logic                        start_flag;
	logic                        end_flag;
	logic signed [vsp_pkg::FRAME_W-1:0] start_frame;
	logic signed [vsp_pkg::FRAME_W-1:0] end_frame;

	modport source (output valid, output frame_index, output start_flag, output end_flag,
		output start_frame, output end_frame, input ready);
	modport sink   (input valid, input frame_index, input start_flag, input end_flag,
		input start_frame, input end_frame, output ready);
endinterface

/* rtl/core/vad_segment_postprocessor.sv */
// Top level of the VAD segment postprocessor: register port, front end, queue, segmenter.
// Depends on vsp_pkg, vsp_if, vsp_front, vsp_queue and vsp_back.
//
// Takes one speech probability beat per frame (unsigned Q0.16) and returns exactly one
// result beat per frame, in order: the one-based frame index, start and end flags, and the
// start and end frame of a segment (-1 when not reported). Probabilities are averaged over
// a window of smooth_len frames (0 acts as 1, values above MAX_WINDOW as MAX_WINDOW) that
// grows from empty; a frame is speech when window sum >= threshold * frames in window.
// A four-state hangover machine applies minimum speech, maximum speech (forced split, new
// segment on the next frame), minimum silence and start padding of max(pad, window).
// Rate: one frame per clock cycle sustained while the result side takes its beats; the
// window keeps a running sum and prefetches its oldest entry from the window memory, so
// the memory's single read port is used once per frame. A result beat passes the window
// stage register, which loads on the edge that accepts its probability beat, then the
// queue entry and then the output register. The front end keeps accepting while the
// result side stalls until its four-entry queue fills. Registers sit at byte addresses 4*i
// on the APB port, pready is tied high, and the user is to write only while the block
// is idle; the block itself does not enforce this. Writing smooth_len empties the
// window. No reset sweep: the block accepts beats right after reset.
module vad_segment_postprocessor #(
	parameter int MAX_WINDOW = vsp_pkg::MAX_WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	vsp_in_if.sink                      frame_in,
	vsp_out_if.source                   result_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vsp_pkg::PADDR_W-1:0] paddr,
	input  logic [vsp_pkg::PDATA_W-1:0] pwdata,
	output logic [vsp_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import vsp_pkg::*;

	localparam int LW = $clog2(MAX_WINDOW + 1);

	logic [SMOOTH_W-1:0] smooth_len_q;
	logic [THR_W-1:0]    speech_threshold_q;
	logic [PAD_W-1:0]    pad_frames_q;
	logic [RUN_W-1:0]    spch_min_q;
	logic [RUN_W-1:0]    spch_max_q;
	logic [RUN_W-1:0]    sil_min_q;

	logic                wr_en;
	logic [2:0]          reg_idx;
	logic                win_clear;
	logic [LW-1:0]       win_len;
	logic [PAD_W-1:0]    pad_eff;
	cfg_t                cfg;

	frame_cls_t          cls_push;
	frame_cls_t          cls_head;
	logic                push_ready;
	logic                cls_pop;

	// Register port: write on the access phase, reads are pure decode
	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite && pready;
	assign reg_idx   = paddr[PADDR_W-1:2];
	assign win_clear = wr_en && (reg_idx == REG_SMOOTH_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_len_q       <= SMOOTH_W'(5);
			speech_threshold_q <= THR_W'(32768);
			pad_frames_q       <= PAD_W'(5);
			spch_min_q         <= RUN_W'(20);
			spch_max_q         <= RUN_W'(2000);
			sil_min_q          <= RUN_W'(70);
		end else if (wr_en) begin
			case (reg_idx)
				REG_SMOOTH_LEN:  smooth_len_q       <= pwdata[SMOOTH_W-1:0];
				REG_SPEECH_THR:  speech_threshold_q <= pwdata[THR_W-1:0];
				REG_PAD_FRAMES:  pad_frames_q       <= pwdata[PAD_W-1:0];
				REG_MIN_SPEECH:  spch_min_q         <= pwdata[RUN_W-1:0];
				REG_MAX_SPEECH:  spch_max_q         <= pwdata[RUN_W-1:0];
				REG_MIN_SILENCE: sil_min_q          <= pwdata[RUN_W-1:0];
				default:         smooth_len_q       <= smooth_len_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SMOOTH_LEN:  prdata = PDATA_W'(smooth_len_q);
			REG_SPEECH_THR:  prdata = PDATA_W'(speech_threshold_q);
			REG_PAD_FRAMES:  prdata = PDATA_W'(pad_frames_q);
			REG_MIN_SPEECH:  prdata = PDATA_W'(spch_min_q);
			REG_MAX_SPEECH:  prdata = PDATA_W'(spch_max_q);
			REG_MIN_SILENCE: prdata = PDATA_W'(sil_min_q);
			default:         prdata = '0;
		endcase
	end

	// Clamp the window length into 1..MAX_WINDOW
	always_comb begin
		if (smooth_len_q == '0) begin
			win_len = LW'(1);
		end else if (32'(smooth_len_q) > 32'(MAX_WINDOW)) begin
			win_len = LW'(MAX_WINDOW);
		end else begin
			win_len = LW'(smooth_len_q);
		end
	end

	// Padding never shorter than the window
	assign pad_eff = (pad_frames_q > PAD_W'(win_len)) ? pad_frames_q : PAD_W'(win_len);

	assign cfg.speech_threshold   = speech_threshold_q;
	assign cfg.pad_frames         = pad_frames_q;
	assign cfg.min_speech_frames  = spch_min_q;
	assign cfg.max_speech_frames  = spch_max_q;
	assign cfg.min_silence_frames = sil_min_q;

	vsp_front #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.frame_in         (frame_in),
		.win_len          (win_len),
		.speech_threshold (cfg.speech_threshold),
		.win_clear        (win_clear),
		.cls              (cls_push),
		.cls_ready        (push_ready)
	);

	vsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cls_push),
		.push_ready (push_ready),
		.head       (cls_head),
		.pop        (cls_pop)
	);

	vsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cls        (cls_head),
		.cls_pop    (cls_pop),
		.cfg        (cfg),
		.pad_eff    (pad_eff),
		.result_out (result_out)
	);

endmodule

/* rtl/core/vsp_front.sv */
// Front end: moving-average window over the probability stream and speech classification.
// Depends on vsp_pkg and vsp_in_if.
module vsp_front #(
	parameter int MAX_WINDOW = vsp_pkg::MAX_WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	vsp_in_if.sink                            frame_in,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]   win_len,
	input  logic [vsp_pkg::THR_W-1:0]         speech_threshold,
	input  logic                              win_clear,
	output vsp_pkg::frame_cls_t               cls,
	input  logic                              cls_ready
);
	import vsp_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LW = $clog2(MAX_WINDOW + 1);
	localparam int SW = PROB_W + LW;
	localparam int TW = LW + 1;

	logic [PROB_W-1:0] win_mem [MAX_WINDOW];
	logic [AW-1:0]     wr_pos_q;
	logic [AW-1:0]     wr_next;
	logic [AW-1:0]     rd_addr;
	logic [TW-1:0]     rd_sum;
	logic [LW-1:0]     fill_q;
	logic [LW-1:0]     fill_next;
	logic [SW-1:0]     sum_q;
	logic [SW-1:0]     sum_next;
	logic [PROB_W-1:0] oldest_q;
	logic              win_full;
	logic              advance;
	logic              accept;
	logic              valid_s1;
	logic [SW-1:0]     sum_s1;
	logic [LW-1:0]     fill_s1;
	logic [SW-1:0]     thr_prod;

	assign advance        = !valid_s1 || cls_ready;
	assign accept         = frame_in.valid && advance;
	assign frame_in.ready = advance;

	assign win_full  = fill_q >= win_len;
	assign sum_next  = sum_q + SW'(frame_in.frame_prob) - (win_full ? SW'(oldest_q) : '0);
	assign fill_next = win_full ? fill_q : fill_q + LW'(1);
	assign wr_next   = (wr_pos_q == AW'(MAX_WINDOW - 1)) ? '0 : wr_pos_q + AW'(1);

	// Oldest entry for the next beat sits win_len places behind the next write slot
	assign rd_sum  = TW'(wr_next) + TW'(MAX_WINDOW) - TW'(win_len);
	assign rd_addr = (rd_sum >= TW'(MAX_WINDOW)) ? AW'(rd_sum - TW'(MAX_WINDOW)) : AW'(rd_sum);

	always_ff @(posedge clk) begin
		if (accept) begin
			win_mem[wr_pos_q] <= frame_in.frame_prob;
			// One-frame window: the oldest entry is the one written now
			if (rd_addr == wr_pos_q) begin
				oldest_q <= frame_in.frame_prob;
			end else begin
				oldest_q <= win_mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			fill_q   <= '0;
			wr_pos_q <= '0;
		end else if (win_clear) begin
			sum_q    <= '0;
			fill_q   <= '0;
			wr_pos_q <= '0;
		end else if (accept) begin
			sum_q    <= sum_next;
			fill_q   <= fill_next;
			wr_pos_q <= wr_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1  <= sum_next;
			fill_s1 <= fill_next;
		end
	end

	// Mean against threshold, kept exact: sum >= threshold * fill
	assign thr_prod   = SW'(speech_threshold) * SW'(fill_s1);
	assign cls.valid  = valid_s1;
	assign cls.speech = sum_s1 >= thr_prod;

endmodule

/* rtl/core/vsp_queue.sv */
// Short queue of classified frames between the front end and the segmenter.
// Depends on vsp_pkg.
module vsp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  vsp_pkg::frame_cls_t push,
	output logic                push_ready,
	output vsp_pkg::frame_cls_t head,
	input  logic                pop
);
	import vsp_pkg::*;

	localparam int CW = QPTR_W + 1;

	logic              speech_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready  = count_q != CW'(QUEUE_DEPTH);
	assign head.valid  = count_q != '0;
	assign head.speech = speech_q[rd_ptr_q];
	assign do_push     = push.valid && push_ready;
	assign do_pop      = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			speech_q[wr_ptr_q] <= push.speech;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/vsp_back.sv */
// Segmenter: hangover state machine, frame counter and registered result beat.
// Depends on vsp_pkg and vsp_out_if.
module vsp_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  vsp_pkg::frame_cls_t       cls,
	output logic                      cls_pop,
	input  vsp_pkg::cfg_t             cfg,
	input  logic [vsp_pkg::PAD_W-1:0] pad_eff,
	vsp_out_if.source                 result_out
);
	import vsp_pkg::*;

	localparam int CAND_W = FRAME_W + 2;

	function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
		return (v == '1) ? v : v + RUN_W'(1);
	endfunction

	vad_mode_t          mode_q, mode_d;
	logic [IDX_W-1:0]   fc_q;
	logic [RUN_W-1:0]   speech_run_q, speech_run_d;
	logic [RUN_W-1:0]   silence_run_q, silence_run_d;
	logic               split_q, split_d;
	logic [FRAME_W-1:0] open_start_q, open_start_d;
	logic [FRAME_W-1:0] closed_next_q, closed_next_d;

	logic               out_valid_q;
	logic [IDX_W-1:0]   frame_index_q;
	logic               start_flag_q, start_flag_d;
	logic               end_flag_q, end_flag_d;
	logic [FRAME_W-1:0] start_frame_q, start_frame_d;
	logic [FRAME_W-1:0] end_frame_q, end_frame_d;

	logic [RUN_W-1:0]   run_inc;
	logic [RUN_W-1:0]   sil_inc;
	logic [FRAME_W-1:0] fc_ext;
	logic [FRAME_W-1:0] open_mid;
	logic               do_split;
	logic signed [CAND_W-1:0] cand;
	logic signed [CAND_W-1:0] cand_lo;
	logic signed [CAND_W-1:0] closed_s;
	logic signed [CAND_W-1:0] cand_hi;
	logic signed [CAND_W-1:0] start_cand;
	logic [FRAME_W-1:0] start_sat;

	assign cls_pop = cls.valid && (!out_valid_q || result_out.ready);

	assign run_inc  = sat_inc(speech_run_q);
	assign sil_inc  = sat_inc(silence_run_q);
	assign fc_ext   = FRAME_W'(fc_q);
	assign open_mid = split_q ? fc_ext : open_start_q;

	// Padded start: max(fc - run + 1 - pad, 1, last end + 1), clipped to 32 bits
	always_comb begin
		cand       = CAND_W'(fc_q) + CAND_W'(1) - CAND_W'(run_inc) - CAND_W'(pad_eff);
		cand_lo    = (cand > CAND_W'(1)) ? cand : CAND_W'(1);
		closed_s   = CAND_W'(closed_next_q);
		cand_hi    = (closed_s > cand_lo) ? closed_s : cand_lo;
		start_cand = (cand_hi > CAND_W'({IDX_W{1'b1}})) ? CAND_W'({IDX_W{1'b1}}) : cand_hi;
		start_sat  = start_cand[FRAME_W-1:0];
	end

	always_comb begin
		mode_d        = mode_q;
		speech_run_d  = speech_run_q;
		silence_run_d = silence_run_q;
		split_d       = split_q;
		open_start_d  = open_start_q;
		closed_next_d = closed_next_q;
		start_flag_d  = 1'b0;
		end_flag_d    = 1'b0;
		start_frame_d = FRAME_NONE;
		end_frame_d   = FRAME_NONE;
		do_split      = 1'b0;

		// New segment opens on the frame after a forced split
		if (split_q) begin
			start_flag_d  = 1'b1;
			start_frame_d = fc_ext;
			open_start_d  = fc_ext;
			split_d       = 1'b0;
		end

		case (mode_q)
			MODE_SILENCE: begin
				if (cls.speech) begin
					mode_d       = MODE_MAYBE_SPEECH;
					speech_run_d = run_inc;
				end else begin
					silence_run_d = sil_inc;
					speech_run_d  = '0;
				end
			end
			MODE_MAYBE_SPEECH: begin
				if (cls.speech) begin
					speech_run_d = run_inc;
					if (run_inc >= cfg.min_speech_frames) begin
						mode_d        = MODE_SPEECH;
						start_flag_d  = 1'b1;
						start_frame_d = start_sat;
						open_start_d  = start_sat;
						silence_run_d = '0;
					end
				end else begin
					mode_d        = MODE_SILENCE;
					silence_run_d = RUN_W'(1);
					speech_run_d  = '0;
				end
			end
			MODE_SPEECH: begin
				speech_run_d = run_inc;
				if (cls.speech) begin
					silence_run_d = '0;
					do_split      = run_inc >= cfg.max_speech_frames;
				end else begin
					mode_d        = MODE_MAYBE_SILENCE;
					silence_run_d = sil_inc;
				end
			end
			MODE_MAYBE_SILENCE: begin
				speech_run_d = run_inc;
				if (cls.speech) begin
					mode_d        = MODE_SPEECH;
					silence_run_d = '0;
					do_split      = run_inc >= cfg.max_speech_frames;
				end else begin
					silence_run_d = sil_inc;
					if (sil_inc >= cfg.min_silence_frames) begin
						mode_d        = MODE_SILENCE;
						end_flag_d    = 1'b1;
						end_frame_d   = fc_ext;
						start_frame_d = open_mid;
						closed_next_d = fc_ext + FRAME_W'(1);
						open_start_d  = FRAME_NONE;
						speech_run_d  = '0;
					end
				end
			end
			default: begin
				mode_d = mode_q;
			end
		endcase

		// Maximum length reached: close here and reopen on the next frame
		if (do_split) begin
			split_d       = 1'b1;
			speech_run_d  = '0;
			end_flag_d    = 1'b1;
			end_frame_d   = fc_ext;
			start_frame_d = open_mid;
			open_start_d  = FRAME_NONE;
			closed_next_d = fc_ext + FRAME_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_SILENCE;
			fc_q          <= IDX_W'(1);
			speech_run_q  <= '0;
			silence_run_q <= '0;
			split_q       <= 1'b0;
			open_start_q  <= FRAME_NONE;
			closed_next_q <= '0;
		end else if (cls_pop) begin
			mode_q        <= mode_d;
			fc_q          <= fc_q + IDX_W'(1);
			speech_run_q  <= speech_run_d;
			silence_run_q <= silence_run_d;
			split_q       <= split_d;
			open_start_q  <= open_start_d;
			closed_next_q <= closed_next_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cls_pop) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cls_pop) begin
			frame_index_q <= fc_q;
			start_flag_q  <= start_flag_d;
			end_flag_q    <= end_flag_d;
			start_frame_q <= start_frame_d;
			end_frame_q   <= end_frame_d;
		end
	end

	assign result_out.valid       = out_valid_q;
	assign result_out.frame_index = frame_index_q;
	assign result_out.start_flag  = start_flag_q;
	assign result_out.end_flag    = end_flag_q;
	assign result_out.start_frame = start_frame_q;
	assign result_out.end_frame   = end_frame_q;

endmodule

/* test/tb_top.sv */
// Testbench for vad_segment_postprocessor: directed corner frames, then phases of random
// speech/silence runs under varied settings, every result beat checked against a prediction.
// Depends on vsp_pkg, vsp_in_if, vsp_out_if and the RTL of the block.
module tb_top;
	import vsp_pkg::*;

	localparam int     WIN_MAX       = MAX_WINDOW_DEF;
	localparam int     STALL_LIMIT   = 1000;
	localparam int     DRAIN_CYCLES  = 8;
	localparam int     RANDOM_PHASES = 9;
	localparam int     PHASE_FRAMES  = 200;
	localparam int     MAX_REPORTS   = 40;
	localparam int     RUN_CEIL      = 65535;
	localparam longint FRAME_CEIL    = 64'h0000_0000_FFFF_FFFF;

	// One result beat as the block should present it
	typedef struct {
		logic [IDX_W-1:0]   frame_index;
		logic               start_flag;
		logic               end_flag;
		logic [FRAME_W-1:0] start_frame;
		logic [FRAME_W-1:0] end_frame;
	} seg_verdict_t;

	// Mirrors the smoothing window and the hangover machine, and holds the verdicts still
	// owed by the block, oldest first.
	class segment_tracker;
		int               smooth_len, speech_thr, pad_frames;
		int               speech_need, speech_cap, silence_need;
		int               win [WIN_MAX];
		int               win_sum, win_fill, wr_pos;
		logic [IDX_W-1:0] frame_tally;
		vad_mode_t        mode;
		int               speech_run, silence_run;
		bit               split_pending;
		longint           open_start, closed_end;
		seg_verdict_t     awaited [$];
		int               mismatches;

		function new();
			smooth_len    = 5;
			speech_thr    = 32768;
			pad_frames    = 5;
			speech_need   = 20;
			speech_cap    = 2000;
			silence_need  = 70;
			win_sum       = 0;
			win_fill      = 0;
			wr_pos        = 0;
			frame_tally   = '0;
			mode          = MODE_SILENCE;
			speech_run    = 0;
			silence_run   = 0;
			split_pending = 1'b0;
			open_start    = -1;
			closed_end    = -1;
			mismatches    = 0;
		endfunction

		function void set_reg(cfg_reg_t which, logic [PDATA_W-1:0] value);
			case (which)
				REG_SMOOTH_LEN: begin
					// a new window length starts from an empty window
					smooth_len = int'(value[SMOOTH_W-1:0]);
					win_sum    = 0;
					win_fill   = 0;
					wr_pos     = 0;
				end
				REG_SPEECH_THR:  speech_thr   = int'(value[THR_W-1:0]);
				REG_PAD_FRAMES:  pad_frames   = int'(value[PAD_W-1:0]);
				REG_MIN_SPEECH:  speech_need  = int'(value[RUN_W-1:0]);
				REG_MAX_SPEECH:  speech_cap   = int'(value[RUN_W-1:0]);
				REG_MIN_SILENCE: silence_need = int'(value[RUN_W-1:0]);
				default: ;
			endcase
		endfunction

		function int bump(int run);
			return (run >= RUN_CEIL) ? RUN_CEIL : run + 1;
		endfunction

		function void split_segment(longint fc, inout seg_verdict_t v);
			split_pending = 1'b1;
			speech_run    = 0;
			v.end_flag    = 1'b1;
			v.end_frame   = fc[FRAME_W-1:0];
			v.start_frame = open_start[FRAME_W-1:0];
			open_start    = -1;
			closed_end    = fc;
		endfunction

		function void predict_frame(logic [PROB_W-1:0] prob);
			int           wlen, pad;
			longint       fc, lead, first;
			bit           speech;
			seg_verdict_t v;
			wlen = (smooth_len < 1) ? 1 : ((smooth_len > WIN_MAX) ? WIN_MAX : smooth_len);
			pad  = (pad_frames > wlen) ? pad_frames : wlen;
			frame_tally = frame_tally + IDX_W'(1);
			fc = {32'd0, frame_tally};
			v.frame_index = frame_tally;
			v.start_flag  = 1'b0;
			v.end_flag    = 1'b0;
			v.start_frame = FRAME_NONE;
			v.end_frame   = FRAME_NONE;

			if (win_fill >= wlen)
				win_sum -= win[(wr_pos + WIN_MAX - wlen) % WIN_MAX];
			else
				win_fill++;
			win[wr_pos] = int'(prob);
			win_sum += int'(prob);
			wr_pos = (wr_pos + 1) % WIN_MAX;
			speech = (win_sum >= speech_thr * win_fill);

			if (split_pending) begin
				v.start_flag  = 1'b1;
				v.start_frame = fc[FRAME_W-1:0];
				open_start    = fc;
				split_pending = 1'b0;
			end

			case (mode)
				MODE_SILENCE: begin
					if (speech) begin
						mode       = MODE_MAYBE_SPEECH;
						speech_run = bump(speech_run);
					end else begin
						silence_run = bump(silence_run);
						speech_run  = 0;
					end
				end
				MODE_MAYBE_SPEECH: begin
					if (speech) begin
						speech_run = bump(speech_run);
						if (speech_run >= speech_need) begin
							// back-date the start by the pad, never before frame one
							// nor into the segment that closed last
							lead  = fc - longint'(speech_run) + 64'sd1 - longint'(pad);
							first = 1;
							if (lead > first)
								first = lead;
							if (closed_end + 1 > first)
								first = closed_end + 1;
							if (first > FRAME_CEIL)
								first = FRAME_CEIL;
							mode          = MODE_SPEECH;
							v.start_flag  = 1'b1;
							v.start_frame = first[FRAME_W-1:0];
							open_start    = first;
							silence_run   = 0;
						end
					end else begin
						mode        = MODE_SILENCE;
						silence_run = 1;
						speech_run  = 0;
					end
				end
				MODE_SPEECH: begin
					speech_run = bump(speech_run);
					if (speech) begin
						silence_run = 0;
						if (speech_run >= speech_cap)
							split_segment(fc, v);
					end else begin
						mode        = MODE_MAYBE_SILENCE;
						silence_run = bump(silence_run);
					end
				end
				default: begin
					speech_run = bump(speech_run);
					if (speech) begin
						mode        = MODE_SPEECH;
						silence_run = 0;
						if (speech_run >= speech_cap)
							split_segment(fc, v);
					end else begin
						silence_run = bump(silence_run);
						if (silence_run >= silence_need) begin
							mode        = MODE_SILENCE;
							v.end_flag  = 1'b1;
							v.end_frame = fc[FRAME_W-1:0];
							v.start_frame = open_start[FRAME_W-1:0];
							closed_end  = fc;
							open_start  = -1;
							speech_run  = 0;
						end
					end
				end
			endcase
			awaited.insert(awaited.size(), v);
		endfunction

		function void compare_field(string name, logic [IDX_W-1:0] index,
			logic [FRAME_W-1:0] want, logic [FRAME_W-1:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t frame %0d %s: expected %h, actual %h",
						$time, index, name, want, got);
			end
		endfunction

		function void check_verdict(seg_verdict_t got);
			seg_verdict_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t result beat with none owed: expected nothing, actual frame %0d",
						$time, got.frame_index);
				return;
			end
			want = awaited[0];
			awaited.delete(0);
			compare_field("frame_index", want.frame_index, FRAME_W'(want.frame_index),
				FRAME_W'(got.frame_index));
			compare_field("start_flag", want.frame_index, FRAME_W'(want.start_flag),
				FRAME_W'(got.start_flag));
			compare_field("end_flag", want.frame_index, FRAME_W'(want.end_flag),
				FRAME_W'(got.end_flag));
			compare_field("start_frame", want.frame_index, want.start_frame, got.start_frame);
			compare_field("end_frame", want.frame_index, want.end_frame, got.end_frame);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 idle_cycles = 0;
	segment_tracker     tracker;

	vsp_in_if  frame_in();
	vsp_out_if result_out();

	vad_segment_postprocessor uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_in),
		.result_out (result_out),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold a setup and then an access cycle; the register takes the value at the end of the access cycle.
	// Drop the select again before any following write raises it.
	task automatic write_setting(input cfg_reg_t which, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_reg(which, value);
		@(posedge clk);
	endtask

	task automatic program_settings(input int smooth, input int thr, input int pad,
		input int min_sp, input int max_sp, input int min_sil);
		write_setting(REG_SMOOTH_LEN, smooth);
		write_setting(REG_SPEECH_THR, thr);
		write_setting(REG_PAD_FRAMES, pad);
		write_setting(REG_MIN_SPEECH, min_sp);
		write_setting(REG_MAX_SPEECH, max_sp);
		write_setting(REG_MIN_SILENCE, min_sil);
	endtask

	// Pick a field value: now and then one of its extremes, otherwise a working value
	function automatic int pick_value(int low_end, int high_end, int lo, int hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return low_end;
		if (r < 24)
			return high_end;
		return $urandom_range(hi, lo);
	endfunction

	task automatic program_random_settings();
		program_settings(pick_value(0, 31, 1, WIN_MAX),
			pick_value(0, 65535, 8192, 57344),
			pick_value(0, 1023, 0, 40),
			pick_value(0, 65535, 1, 12),
			pick_value(0, 65535, 2, 80),
			pick_value(0, 65535, 1, 20));
	endtask

	// Probability on the speech or the silence side of the current threshold
	function automatic logic [PROB_W-1:0] level_for(bit loud);
		int thr;
		thr = tracker.speech_thr;
		if (loud)
			return PROB_W'($urandom_range(65535, thr));
		if (thr == 0)
			return '0;
		return PROB_W'($urandom_range(thr - 1, 0));
	endfunction

	// Mostly back-to-back beats, some short gaps, a few long ones
	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one probability beat after an optional gap and wait for the handshake.
	// Valid stays high afterwards so that the next beat can follow without a bubble.
	task automatic send_frame(input logic [PROB_W-1:0] prob, input int gap);
		if (gap > 0) begin
			frame_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_in.valid      <= 1'b1;
		frame_in.frame_prob <= prob;
		do
			@(posedge clk);
		while (!frame_in.ready);
		tracker.predict_frame(prob);
	endtask

	// Stop offering beats and wait until every owed result has come out
	task automatic settle_block();
		frame_in.valid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Runs of speech-level or silence-level frames with random content; some runs are
	// long enough to satisfy the reset-time minimums, and a tenth of the beats are noise.
	task automatic play_random(input int count);
		int               sent, run_len;
		bit               loud, steady;
		logic [PROB_W-1:0] prob;
		sent = 0;
		while (sent < count) begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150)
				: $urandom_range(1, 25);
			loud    = ($urandom_range(0, 1) == 1);
			steady  = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < run_len && sent < count; k++) begin
				if ($urandom_range(0, 9) == 0)
					prob = PROB_W'($urandom);
				else
					prob = level_for(loud);
				send_frame(prob, pick_gap(steady));
				sent++;
				// once in a while, hold the stream until the output side has caught up
				if ($urandom_range(0, 399) == 0)
					settle_block();
			end
		end
	endtask

	// Result side: open for a while, then stall for none, a few or many cycles
	initial begin
		int open_len, shut_len, r;
		result_out.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
			result_out.ready <= 1'b1;
			repeat (open_len) @(posedge clk);
			r = $urandom_range(0, 9);
			shut_len = (r < 3) ? 0 : ((r < 9) ? $urandom_range(1, 4) : $urandom_range(10, 40));
			if (shut_len > 0) begin
				result_out.ready <= 1'b0;
				repeat (shut_len) @(posedge clk);
			end
		end
	end

	// Check every result beat on the edge that accepts it
	always @(posedge clk) begin
		seg_verdict_t got;
		if (arst_n && result_out.valid && result_out.ready) begin
			got.frame_index = result_out.frame_index;
			got.start_flag  = result_out.start_flag;
			got.end_flag    = result_out.end_flag;
			got.start_frame = result_out.start_frame;
			got.end_frame   = result_out.end_frame;
			tracker.check_verdict(got);
		end
	end

	// Drop the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (frame_in.valid && frame_in.ready)
			|| (result_out.valid && result_out.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [PROB_W-1:0] corner_probs [8] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
			16'h0001, 16'hAAAA, 16'h5555, 16'h0000};
		tracker = new();
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		frame_in.valid      <= 1'b0;
		frame_in.frame_prob <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: probability extremes and the threshold boundary
		foreach (corner_probs[i])
			send_frame(corner_probs[i], 0);

		// Zero window length and zero minimums/maximum, threshold zero: every frame is
		// speech, each segment splits at once, and a pending split start lands on the
		// same frame as the next forced end
		settle_block();
		program_settings(0, 0, 0, 0, 0, 0);
		repeat (6) send_frame('0, 0);

		// Window length beyond the store, full-scale threshold and maximum pad: the start
		// is clamped by the segment that closed last; silent frames break the window
		settle_block();
		program_settings(31, 65535, 1023, 1, 4, 1);
		repeat (6) send_frame(16'hFFFF, 0);
		repeat (2) send_frame(16'h0000, 1);
		repeat (3) send_frame(16'hFFFF, 0);

		// Random phases: first at the reset-time settings, then freshly drawn ones
		settle_block();
		program_settings(5, 32768, 5, 20, 2000, 70);
		play_random(PHASE_FRAMES);
		for (int ph = 1; ph < RANDOM_PHASES; ph++) begin
			settle_block();
			program_random_settings();
			play_random(PHASE_FRAMES);
		end

		// Drain, then give the block a few more cycles to show any stray beat
		frame_in.valid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
